### rtl/clcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

    typedef enum logic [1:0] {
        OP_CMD      = 2'd0,
        OP_DATA     = 2'd1,
        OP_SET_POS  = 2'd2,
        OP_MOVE_POS = 2'd3
    } t_opcode;

    // configuration register indexes
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;

    localparam logic [5:0] COLUMNS_RESET = 6'd16;
    localparam logic [2:0] ROWS_RESET    = 3'd2;
    localparam logic [5:0] COL_LIMIT     = 6'd40;

    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic       BACKLIGHT_ON  = 1'b1;

    // position in the six-byte sequence
    localparam logic [2:0] BEAT_FIRST  = 3'd0;
    localparam logic [2:0] BEAT_EN_HI  = 3'd1;
    localparam logic [2:0] BEAT_LO     = 3'd3;
    localparam logic [2:0] BEAT_EN_LO  = 3'd4;
    localparam logic [2:0] BEAT_LAST   = 3'd5;

    typedef struct packed {
        logic [7:0] cmd_byte;
        logic       rs;
        logic [5:0] cursor_col;
        logic [1:0] cursor_row;
    } t_cmd;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        unique case (row)
            2'd0:    base = 8'h00;
            2'd1:    base = 8'h40;
            2'd2:    base = 8'h14;
            default: base = 8'h54;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

### rtl/clcd_addr_calc.sv
`timescale 1ns / 1ps
`default_nettype none

module clcd_addr_calc #(
    parameter int MAX_ROWS = 4
) (
    input  var clcd_pkg::t_opcode    i_op,
    input  var logic [7:0]           i_byte_value,
    input  var logic signed [7:0]    i_col_arg,
    input  var logic signed [7:0]    i_row_arg,
    input  var logic [5:0]           i_cursor_col,
    input  var logic [1:0]           i_cursor_row,
    input  var logic [5:0]           i_columns,
    input  var logic [2:0]           i_rows,
    output clcd_pkg::t_cmd           o_cmd
);
    import clcd_pkg::*;

    localparam logic [2:0] MaxRows = 3'(MAX_ROWS);

    logic [5:0]        ncol;
    logic [2:0]        nrow;
    logic signed [8:0] tc;
    logic signed [8:0] tr;
    logic [5:0]        new_col;
    logic [1:0]        new_row;
    logic              is_move;

    always_comb begin
        // display size clamped to what the panel can have
        if (i_columns == 6'd0) begin
            ncol = 6'd1;
        end else if (i_columns > COL_LIMIT) begin
            ncol = COL_LIMIT;
        end else begin
            ncol = i_columns;
        end
        if (i_rows == 3'd0) begin
            nrow = 3'd1;
        end else if (i_rows > MaxRows) begin
            nrow = MaxRows;
        end else begin
            nrow = i_rows;
        end

        is_move = (i_op == OP_MOVE_POS);
        tc = $signed({i_col_arg[7], i_col_arg})
           + (is_move ? $signed({3'b000, i_cursor_col}) : 9'sd0);
        tr = $signed({i_row_arg[7], i_row_arg})
           + (is_move ? $signed({7'b0000000, i_cursor_row}) : 9'sd0);

        if (tc[8]) begin
            new_col = 6'd0;
        end else if (tc[7:0] >= {2'b00, ncol}) begin
            new_col = ncol - 6'd1;
        end else begin
            new_col = tc[5:0];
        end

        if (tr[8]) begin
            new_row = 2'd0;
        end else if (tr[7:0] >= {5'b00000, nrow}) begin
            new_row = 2'(nrow - 3'd1);
        end else begin
            new_row = tr[1:0];
        end

        unique case (i_op)
            OP_CMD: begin
                o_cmd.cmd_byte   = i_byte_value;
                o_cmd.rs         = 1'b0;
                o_cmd.cursor_col = i_cursor_col;
                o_cmd.cursor_row = i_cursor_row;
            end
            OP_DATA: begin
                o_cmd.cmd_byte   = i_byte_value;
                o_cmd.rs         = 1'b1;
                o_cmd.cursor_col = i_cursor_col;
                o_cmd.cursor_row = i_cursor_row;
            end
            OP_SET_POS, OP_MOVE_POS: begin
                o_cmd.cmd_byte   = {2'b00, new_col} + (CMD_SET_DDRAM | row_base(new_row));
                o_cmd.rs         = 1'b0;
                o_cmd.cursor_col = new_col;
                o_cmd.cursor_row = new_row;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/char_lcd_i2c_nibble_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_opcode, i_byte_value, i_col_arg, i_row_arg
// output    out        o_valid / i_stall   o_expander_byte, o_last
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// every item gives six expander bytes, one per cycle while the output is not
// stalled; the byte serializer sends them.
// an item waits in the input register while the previous item is still sent,
// and moves to the serializer in the cycle its last byte is taken.
// an accepted item passes the input register and is loaded into the serializer
// before its first byte shows, or waits behind the previous item; stalls add.
// synchronous active-low reset clears valids and cursor and sets the size registers to their reset values.
module char_lcd_i2c_nibble_sequencer #(
    parameter int MAX_ROWS = 4
) (
    input  var logic              i_clk,
    input  var logic              i_rst_n,
    input  var logic              i_cfg_we,
    input  var logic [1:0]        i_cfg_idx,
    input  var logic [5:0]        i_cfg_data,
    input  var logic              i_valid,
    output var logic              o_stall,
    input  var logic [1:0]        i_opcode,
    input  var logic [7:0]        i_byte_value,
    input  var logic signed [7:0] i_col_arg,
    input  var logic signed [7:0] i_row_arg,
    output var logic              o_valid,
    input  var logic              i_stall,
    output var logic [7:0]        o_expander_byte,
    output var logic              o_last
);
    import clcd_pkg::*;

    logic [5:0]        r_columns;
    logic [2:0]        r_rows;
    logic [5:0]        r_cursor_col;
    logic [1:0]        r_cursor_row;

    logic              r_in_valid;
    t_opcode           r_op;
    logic [7:0]        r_byte;
    logic signed [7:0] r_col;
    logic signed [7:0] r_row;

    logic              r_busy;
    logic [2:0]        r_beat;
    logic [2:0]        n_beat;
    logic [7:0]        r_cmd_byte;
    logic              r_rs;

    t_cmd              calc;
    logic              out_take;
    logic              load;
    logic              in_take;
    logic [3:0]        nib;
    logic              enable;

    clcd_addr_calc #(
        .MAX_ROWS(MAX_ROWS)
    ) u_addr_calc (
        .i_op         (r_op),
        .i_byte_value (r_byte),
        .i_col_arg    (r_col),
        .i_row_arg    (r_row),
        .i_cursor_col (r_cursor_col),
        .i_cursor_row (r_cursor_row),
        .i_columns    (r_columns),
        .i_rows       (r_rows),
        .o_cmd        (calc)
    );

    assign out_take = r_busy && !i_stall;
    // serializer is free, or frees up this cycle
    assign load     = r_in_valid && (!r_busy || (out_take && r_beat == BEAT_LAST));
    assign o_stall  = r_in_valid && !load;
    assign in_take  = i_valid && !o_stall;
    assign n_beat   = r_beat + 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= COLUMNS_RESET;
            r_rows    <= ROWS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_COLUMNS) begin
                r_columns <= i_cfg_data;
            end else if (i_cfg_idx == REG_ROWS) begin
                r_rows <= i_cfg_data[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op   <= t_opcode'(i_opcode);
            r_byte <= i_byte_value;
            r_col  <= i_col_arg;
            r_row  <= i_row_arg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_beat       <= BEAT_FIRST;
            r_cursor_col <= 6'd0;
            r_cursor_row <= 2'd0;
        end else if (load) begin
            r_busy       <= 1'b1;
            r_beat       <= BEAT_FIRST;
            r_cursor_col <= calc.cursor_col;
            r_cursor_row <= calc.cursor_row;
        end else if (out_take) begin
            if (r_beat == BEAT_LAST) begin
                r_busy <= 1'b0;
                r_beat <= BEAT_FIRST;
            end else begin
                r_beat <= n_beat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd_byte <= calc.cmd_byte;
            r_rs       <= calc.rs;
        end
    end

    // high nibble for the first three beats, low nibble for the last three, enable strobe in the middle one of each
    assign nib    = (r_beat < BEAT_LO) ? r_cmd_byte[7:4] : r_cmd_byte[3:0];
    assign enable = (r_beat == BEAT_EN_HI) || (r_beat == BEAT_EN_LO);

    assign o_valid         = r_busy;
    assign o_expander_byte = {nib, BACKLIGHT_ON, enable, 1'b0, r_rs};
    assign o_last          = r_busy && (r_beat == BEAT_LAST);

endmodule

`default_nettype wire

### rtl/clcd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module clcd_checker (
    input var logic       i_clk,
    input var logic       i_rst_n,
    input var logic       o_valid,
    input var logic       i_stall,
    input var logic [7:0] o_expander_byte,
    input var logic       o_last
);

    // a held item keeps its byte
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_expander_byte) && $stable(o_last))
        else $error("output item changed while stalled");

    a_backlight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_expander_byte[3])
        else $error("backlight bit clear on an output item");

    // an enable strobe that is taken is followed by the same nibble with enable low
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_expander_byte[2] && !i_stall |=>
            o_valid && !o_expander_byte[2]
            && o_expander_byte[7:4] == $past(o_expander_byte[7:4])
            && o_expander_byte[0] == $past(o_expander_byte[0]))
        else $error("enable strobe not closed by its nibble");

    a_last_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid && !o_expander_byte[2])
        else $error("last item is not a closing byte");

endmodule

bind char_lcd_i2c_nibble_sequencer clcd_checker u_clcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_expander_byte (o_expander_byte),
    .o_last          (o_last)
);

`default_nettype wire

### tb/char_lcd_i2c_nibble_sequencer_tb.sv
`timescale 1ns / 1ps

module char_lcd_i2c_nibble_sequencer_tb;
    import clcd_pkg::*;

    localparam int DISPLAY_MAX_ROWS = 4;
    localparam int IDLE_LIMIT       = 2000;
    localparam int PHASE_ITEMS      = 30;

    // index values that map to no register
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    localparam logic [7:0] BACKLIGHT_BIT = 8'h08;
    localparam logic [7:0] ENABLE_BIT    = 8'h04;
    localparam logic [7:0] ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    localparam logic [5:0] PHASE_COLS [6] = '{6'd16, 6'd40, 6'd1, 6'd20, 6'd63, 6'd0};
    localparam logic [5:0] PHASE_ROWS [6] = '{6'd2, 6'd4, 6'd1, 6'd3, 6'd7, 6'd0};

    typedef struct {
        logic [7:0] xbyte;
        logic       is_last;
    } t_lcd_beat;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_cfg_we     = 1'b0;
    logic [1:0]        i_cfg_idx    = '0;
    logic [5:0]        i_cfg_data   = '0;
    logic              i_valid      = 1'b0;
    logic              o_stall;
    logic [1:0]        i_opcode     = '0;
    logic [7:0]        i_byte_value = '0;
    logic signed [7:0] i_col_arg    = '0;
    logic signed [7:0] i_row_arg    = '0;
    logic              o_valid;
    logic              i_stall      = 1'b0;
    logic [7:0]        o_expander_byte;
    logic              o_last;

    // display size and cursor as the block should hold them
    logic [5:0] disp_columns = COLUMNS_RESET;
    logic [2:0] disp_rows    = ROWS_RESET;
    logic [5:0] shadow_col   = '0;
    logic [1:0] shadow_row   = '0;

    t_lcd_beat expander_expect [$];
    int        mismatch_count = 0;
    int        idle_cycles    = 0;
    int        stall_left     = 0;
    logic      steady_flow    = 1'b0;

    char_lcd_i2c_nibble_sequencer #(
        .MAX_ROWS(DISPLAY_MAX_ROWS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_byte_value   (i_byte_value),
        .i_col_arg      (i_col_arg),
        .i_row_arg      (i_row_arg),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_expander_byte(o_expander_byte),
        .o_last         (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 30);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("mismatch %s: expected %02h got %02h at %0t", what, want, got, $time);
        mismatch_count++;
    endtask

    task automatic push_nibble(input logic [3:0] nib, input logic rs, input logic closing);
        logic [7:0] base;
        base = {nib, 4'b0000} | BACKLIGHT_BIT | {7'd0, rs};
        expander_expect.push_back('{base, 1'b0});
        expander_expect.push_back('{base | ENABLE_BIT, 1'b0});
        expander_expect.push_back('{base & ~ENABLE_BIT, closing});
    endtask

    task automatic predict_expander_bytes(input t_opcode op, input logic [7:0] value,
                                          input logic signed [7:0] col,
                                          input logic signed [7:0] row);
        int         ncol;
        int         nrow;
        int         tc;
        int         tr;
        logic [7:0] cmd;
        cmd = value;
        if (op == OP_SET_POS || op == OP_MOVE_POS) begin
            ncol = int'(disp_columns);
            nrow = int'(disp_rows);
            if (ncol < 1) ncol = 1;
            if (ncol > int'(COL_LIMIT)) ncol = int'(COL_LIMIT);
            if (nrow < 1) nrow = 1;
            if (nrow > DISPLAY_MAX_ROWS) nrow = DISPLAY_MAX_ROWS;
            tc = col;
            tr = row;
            if (op == OP_MOVE_POS) begin
                tc += int'(shadow_col);
                tr += int'(shadow_row);
            end
            if (tc < 0) tc = 0;
            if (tc >= ncol) tc = ncol - 1;
            if (tr < 0) tr = 0;
            if (tr >= nrow) tr = nrow - 1;
            shadow_col = tc[5:0];
            shadow_row = tr[1:0];
            cmd = (CMD_SET_DDRAM | ROW_OFFSET[shadow_row]) + {2'b00, shadow_col};
        end
        push_nibble(cmd[7:4], op == OP_DATA, 1'b0);
        push_nibble(cmd[3:0], op == OP_DATA, 1'b1);
    endtask

    // valid stays high into the next item unless a gap is taken
    task automatic send_item(input t_opcode op, input logic [7:0] value,
                             input logic [7:0] col, input logic [7:0] row);
        int unsigned gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_byte_value <= value;
        i_col_arg    <= col;
        i_row_arg    <= row;
        do @(posedge i_clk); while (o_stall);
        predict_expander_bytes(op, value, col, row);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expander_expect.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [5:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_COLUMNS) begin
            disp_columns = data;
        end else if (idx == REG_ROWS) begin
            disp_rows = data[2:0];
        end
        @(posedge i_clk);
    endtask

    task automatic set_display(input logic [5:0] cols, input logic [5:0] rows);
        wait_drained();
        cfg_write(REG_COLUMNS, cols);
        cfg_write(REG_ROWS, rows);
    endtask

    task automatic send_random_item();
        t_opcode    op;
        logic [7:0] col;
        logic [7:0] row;
        op = t_opcode'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 3) begin
            col = 8'($urandom());
            row = 8'($urandom());
        end else if (op == OP_MOVE_POS) begin
            col = 8'(int'($urandom_range(0, 16)) - 8);
            row = 8'(int'($urandom_range(0, 4)) - 2);
        end else begin
            col = 8'(int'($urandom_range(0, 44)) - 2);
            row = 8'(int'($urandom_range(0, 5)) - 1);
        end
        send_item(op, 8'($urandom()), col, row);
    endtask

    task automatic test_byte_items();
        send_item(OP_CMD, 8'h00, 8'h00, 8'h00);
        send_item(OP_CMD, 8'hFF, 8'h80, 8'h80);
        send_item(OP_DATA, 8'h00, 8'h7F, 8'h7F);
        send_item(OP_DATA, 8'hFF, 8'h55, 8'hAA);
    endtask

    task automatic test_set_position();
        send_item(OP_SET_POS, 8'hFF, 8'h80, 8'h80);
        send_item(OP_SET_POS, 8'h00, 8'h7F, 8'h7F);
        send_item(OP_SET_POS, 8'hA5, 8'h00, 8'h00);
        send_item(OP_SET_POS, 8'h5A, 8'd15, 8'd1);
        send_item(OP_SET_POS, 8'h00, 8'd16, 8'd2);
    endtask

    task automatic test_move_position();
        send_item(OP_SET_POS, 8'h00, 8'd3, 8'd0);
        send_item(OP_MOVE_POS, 8'h00, 8'd1, 8'd1);
        send_item(OP_MOVE_POS, 8'hFF, 8'hFF, 8'h00);
        // byte items must leave the cursor alone
        send_item(OP_CMD, 8'h01, 8'h11, 8'h22);
        send_item(OP_DATA, 8'h41, 8'hEE, 8'hDD);
        send_item(OP_MOVE_POS, 8'h00, 8'h00, 8'h00);
        send_item(OP_MOVE_POS, 8'h00, 8'h7F, 8'h7F);
        send_item(OP_MOVE_POS, 8'h00, 8'h80, 8'h80);
    endtask

    task automatic test_display_sizes();
        // zero size acts as one
        set_display(6'd0, 6'd0);
        send_item(OP_SET_POS, 8'h00, 8'd5, 8'd5);
        send_item(OP_MOVE_POS, 8'h00, 8'd1, 8'd1);
        // oversize clamps to 40 x MAX_ROWS
        set_display(6'd63, 6'd7);
        send_item(OP_SET_POS, 8'h00, 8'h7F, 8'h7F);
        send_item(OP_MOVE_POS, 8'h00, 8'hFF, 8'hFF);
        set_display(6'd40, 6'd4);
        send_item(OP_SET_POS, 8'h00, 8'd39, 8'd3);
        set_display(6'd1, 6'd1);
        send_item(OP_SET_POS, 8'h00, 8'd3, 8'd3);
        // writes to spare indexes go nowhere
        wait_drained();
        cfg_write(REG_SPARE_A, 6'h3F);
        cfg_write(REG_SPARE_B, 6'h2A);
        send_item(OP_SET_POS, 8'h00, 8'h7F, 8'h7F);
        // rows keeps only its low three bits
        wait_drained();
        cfg_write(REG_ROWS, 6'h3A);
        send_item(OP_SET_POS, 8'h00, 8'h7F, 8'h7F);
        set_display(COLUMNS_RESET, {3'b000, ROWS_RESET});
    endtask

    task automatic test_random_traffic();
        logic [5:0] cols;
        logic [5:0] rows;
        for (int p = 0; p < 8; p++) begin
            cols = (p < 6) ? PHASE_COLS[p] : 6'($urandom_range(0, 63));
            rows = (p < 6) ? PHASE_ROWS[p] : 6'($urandom_range(0, 63));
            set_display(cols, rows);
            steady_flow <= (p == 2) || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off now and then until the output side catches up
                if ($urandom_range(0, 39) == 0) wait_drained();
                send_random_item();
            end
        end
        steady_flow <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || steady_flow) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= pick_gap();
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_lcd_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expander_expect.size() == 0) begin
                report_mismatch("unexpected byte", 8'h00, o_expander_byte);
            end else begin
                want = expander_expect.pop_front();
                if (o_expander_byte !== want.xbyte) begin
                    report_mismatch("expander byte", want.xbyte, o_expander_byte);
                end
                if (o_last !== want.is_last) begin
                    report_mismatch("last flag", {7'd0, want.is_last}, {7'd0, o_last});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_byte_items();
        test_set_position();
        test_move_position();
        test_display_sizes();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expander_expect.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
